// ----- design/bfq_pkg.sv -----
// ----------------------------------------------------------------------------
// bfq_pkg
// Shared types and constants for the bitmap font glyph quad generator.
// ----------------------------------------------------------------------------
package bfq_pkg;

  localparam int WidthTableDepth = 256;
  localparam int TableIdxW       = (WidthTableDepth > 1) ? $clog2(WidthTableDepth) : 1;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegFirstCode    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLastCode     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGlyphsPerRow = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCellWidth    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCellHeight   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegUStep        = 3'd5;
  localparam logic [CfgIdxW-1:0] RegVStep        = 3'd6;
  localparam logic [CfgIdxW-1:0] RegAlignment    = 3'd7;

  localparam logic [1:0] ActLoadWidth = 2'd0;
  localparam logic [1:0] ActChar      = 2'd1;
  localparam logic [1:0] ActEnd       = 2'd2;

  localparam logic KindVertex = 1'b0;
  localparam logic KindAlign  = 1'b1;

  localparam logic [1:0] AlignNone   = 2'd0;
  localparam logic [1:0] AlignCenter = 2'd1;

  localparam int DivDividendW = 24;
  localparam int DivDivisorW  = 8;
  localparam int DivSteps     = DivDividendW;
  localparam int DivCntW      = $clog2(DivSteps + 1);

  typedef struct packed {
    logic                    start;
    logic [DivDividendW-1:0] dividend;
    logic [DivDivisorW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic [DivDividendW-1:0] quotient;
    logic [DivDivisorW-1:0]  remainder;
  } div_rsp_t;

endpackage

// ----- design/bfq_width_ram.sv -----
// ----------------------------------------------------------------------------
// bfq_width_ram
// Simple one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfq_width_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/bfq_divider.sv -----
// ----------------------------------------------------------------------------
// bfq_divider
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bfq_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  bfq_pkg::div_req_t req,
  output bfq_pkg::div_rsp_t rsp
);

  logic [bfq_pkg::DivDividendW-1:0] quo_r, quo_nxt;
  logic [bfq_pkg::DivDivisorW-1:0]  rem_r, rem_nxt;
  logic [bfq_pkg::DivDivisorW-1:0]  dsr_r, dsr_nxt;
  logic [bfq_pkg::DivCntW-1:0]      cnt_r, cnt_nxt;
  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;

  logic [bfq_pkg::DivDivisorW:0] shifted;
  logic [bfq_pkg::DivDivisorW:0] trial;

  assign shifted = {rem_r, quo_r[bfq_pkg::DivDividendW-1]};
  assign trial   = shifted - {1'b0, dsr_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      cnt_nxt  = bfq_pkg::DivCntW'(bfq_pkg::DivSteps);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[bfq_pkg::DivDivisorW]) begin
        rem_nxt = shifted[bfq_pkg::DivDivisorW-1:0];
        quo_nxt = {quo_r[bfq_pkg::DivDividendW-2:0], 1'b0};
      end else begin
        rem_nxt = trial[bfq_pkg::DivDivisorW-1:0];
        quo_nxt = {quo_r[bfq_pkg::DivDividendW-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == bfq_pkg::DivCntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

// ----- design/bitmap_font_glyph_quad_generator_unit.sv -----
// ----------------------------------------------------------------------------
// bitmap_font_glyph_quad_generator_unit
// Turns character codes into six textured vertices per glyph.
// ----------------------------------------------------------------------------
// Width loads, out-of-range characters and unused actions leave the unit idle.
// An end-of-string transaction waits for the output register to be free and
// yields one alignment result. A character in range stalls the input from
// acceptance until its last vertex is issued, later when the sink stalls:
// row/column and the scaled glyph texture width are each found by one shared
// 24-step bit-serial divider, which with its start and handoff states and the
// multiply/add steps comes before the first vertex, followed by six vertex
// transactions that leave through the output register at one per cycle when
// the sink does not stall.
module bitmap_font_glyph_quad_generator_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bfq_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [bfq_pkg::CfgDataW-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_action,
  input  logic [7:0]                          in_code,
  input  logic [7:0]                          in_width_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_kind,
  output logic [15:0]                         out_vertex_x,
  output logic [7:0]                          out_vertex_y,
  output logic [15:0]                         out_tex_u,
  output logic [15:0]                         out_tex_v,
  output logic signed [17:0]                  out_offset_x_half,
  output logic signed [9:0]                   out_offset_y_half,
  output logic                                out_last
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StD1S  = 4'd1;
  localparam logic [3:0] StD1W  = 4'd2;
  localparam logic [3:0] StMU   = 4'd3;
  localparam logic [3:0] StMV   = 4'd4;
  localparam logic [3:0] StD2S  = 4'd5;
  localparam logic [3:0] StD2W  = 4'd6;
  localparam logic [3:0] StEmit = 4'd7;
  localparam logic [3:0] StEos  = 4'd8;

  function automatic logic [15:0] sat16_24(input logic [23:0] v);
    return (|v[23:16]) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [15:0] sat16_25(input logic [24:0] v);
    return (|v[24:16]) ? 16'hFFFF : v[15:0];
  endfunction

  // configuration
  logic [7:0]  first_code_r, last_code_r, gpr_r, cell_w_r, cell_h_r;
  logic [15:0] u_step_r, v_step_r;
  logic [3:0]  align_r;

  // sequencer and datapath
  logic [3:0]  state_r, state_nxt;
  logic [2:0]  vtx_r, vtx_nxt;
  logic [15:0] pen_r, pen_nxt;
  logic [7:0]  n_r, n_nxt;
  logic        tab_ok_r, tab_ok_nxt;
  logic [7:0]  w_r, w_nxt;
  logic [7:0]  row_r, row_nxt;
  logic [7:0]  col_r, col_nxt;
  logic [15:0] u0_r, u0_nxt, u1_r, u1_nxt;
  logic [15:0] v0_r, v0_nxt, v1_r, v1_nxt;
  logic [15:0] x1_r, x1_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_kind_nxt;
  logic [15:0] out_x_r, out_x_nxt;
  logic [7:0]  out_y_r, out_y_nxt;
  logic [15:0] out_u_r, out_u_nxt;
  logic [15:0] out_v_r, out_v_nxt;
  logic [17:0] out_ox_r, out_ox_nxt;
  logic [9:0]  out_oy_r, out_oy_nxt;
  logic        out_last_r, out_last_nxt;

  logic        in_accept;
  logic        out_free;
  logic        code_in_range;
  logic        code_in_table;
  logic [7:0]  gpr_eff, cw_eff;
  logic [15:0] mul_a;
  logic [7:0]  mul_b;
  logic [23:0] mul_p;
  logic        ram_we, ram_re;
  logic [7:0]  ram_rdata;
  logic [17:0] mx;
  logic [9:0]  my;
  logic        use_x1, top_row;

  bfq_pkg::div_req_t div_req;
  bfq_pkg::div_rsp_t div_rsp;

  assign in_stall  = (state_r != StIdle);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign code_in_range = (in_code >= first_code_r) && (in_code <= last_code_r);
  assign code_in_table = ({1'b0, in_code} < 9'(bfq_pkg::WidthTableDepth));
  assign gpr_eff       = (gpr_r == 8'd0) ? 8'd1 : gpr_r;
  assign cw_eff        = (cell_w_r == 8'd0) ? 8'd1 : cell_w_r;

  assign ram_we = in_accept && (in_action == bfq_pkg::ActLoadWidth) && code_in_table;
  assign ram_re = in_accept && (in_action == bfq_pkg::ActChar);

  bfq_width_ram #(
    .DEPTH(bfq_pkg::WidthTableDepth),
    .WIDTH(8)
  ) u_width_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(in_code[bfq_pkg::TableIdxW-1:0]),
    .wdata(in_width_value),
    .re   (ram_re),
    .raddr(in_code[bfq_pkg::TableIdxW-1:0]),
    .rdata(ram_rdata)
  );

  bfq_divider u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // shared multiplier
  always_comb begin
    case (state_r)
      StMU: begin
        mul_a = u_step_r;
        mul_b = col_r;
      end
      StMV: begin
        mul_a = v_step_r;
        mul_b = row_r;
      end
      StD2S: begin
        mul_a = u_step_r;
        mul_b = w_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = {8'b0, mul_a} * {16'b0, mul_b};

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {16'b0, n_r};
    div_req.divisor  = gpr_eff;
    if (state_r == StD1S) begin
      div_req.start = 1'b1;
    end else if (state_r == StD2S) begin
      div_req.start    = 1'b1;
      div_req.dividend = mul_p;
      div_req.divisor  = cw_eff;
    end
  end

  always_comb begin
    case (align_r[1:0])
      bfq_pkg::AlignNone:   mx = '0;
      bfq_pkg::AlignCenter: mx = {2'b0, pen_r};
      default:              mx = {1'b0, pen_r, 1'b0};
    endcase
    case (align_r[3:2])
      bfq_pkg::AlignNone:   my = '0;
      bfq_pkg::AlignCenter: my = {2'b0, cell_h_r};
      default:              my = {1'b0, cell_h_r, 1'b0};
    endcase
  end

  assign use_x1  = (vtx_r == 3'd2) || (vtx_r == 3'd3) || (vtx_r == 3'd4);
  assign top_row = vtx_r[0];

  always_comb begin
    state_nxt     = state_r;
    vtx_nxt       = vtx_r;
    pen_nxt       = pen_r;
    n_nxt         = n_r;
    tab_ok_nxt    = tab_ok_r;
    w_nxt         = w_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    u0_nxt        = u0_r;
    u1_nxt        = u1_r;
    v0_nxt        = v0_r;
    v1_nxt        = v1_r;
    x1_nxt        = x1_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_u_nxt     = out_u_r;
    out_v_nxt     = out_v_r;
    out_ox_nxt    = out_ox_r;
    out_oy_nxt    = out_oy_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      StIdle: begin
        if (in_accept) begin
          if ((in_action == bfq_pkg::ActChar) && code_in_range) begin
            n_nxt      = in_code - first_code_r;
            tab_ok_nxt = code_in_table;
            state_nxt  = StD1S;
          end else if (in_action == bfq_pkg::ActEnd) begin
            state_nxt = StEos;
          end
        end
      end
      StD1S: begin
        w_nxt     = tab_ok_r ? ram_rdata : 8'd0;
        state_nxt = StD1W;
      end
      StD1W: begin
        if (div_rsp.done) begin
          row_nxt   = div_rsp.quotient[7:0];
          col_nxt   = div_rsp.remainder;
          state_nxt = StMU;
        end
      end
      StMU: begin
        u0_nxt    = sat16_24(mul_p);
        x1_nxt    = sat16_25({9'b0, pen_r} + {17'b0, w_r});
        state_nxt = StMV;
      end
      StMV: begin
        v0_nxt    = sat16_24(mul_p);
        state_nxt = StD2S;
      end
      StD2S: begin
        v1_nxt    = sat16_25({9'b0, v0_r} + {9'b0, v_step_r});
        state_nxt = StD2W;
      end
      StD2W: begin
        if (div_rsp.done) begin
          u1_nxt    = sat16_25({9'b0, u0_r} + {1'b0, div_rsp.quotient});
          vtx_nxt   = '0;
          state_nxt = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = bfq_pkg::KindVertex;
          out_x_nxt     = use_x1 ? x1_r : pen_r;
          out_y_nxt     = top_row ? cell_h_r : 8'd0;
          out_u_nxt     = use_x1 ? u1_r : u0_r;
          out_v_nxt     = top_row ? v0_r : v1_r;
          out_ox_nxt    = '0;
          out_oy_nxt    = '0;
          out_last_nxt  = (vtx_r == 3'd5);
          vtx_nxt       = vtx_r + 3'd1;
          if (vtx_r == 3'd5) begin
            pen_nxt   = x1_r;
            state_nxt = StIdle;
          end
        end
      end
      StEos: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = bfq_pkg::KindAlign;
          out_x_nxt     = '0;
          out_y_nxt     = '0;
          out_u_nxt     = '0;
          out_v_nxt     = '0;
          out_ox_nxt    = 18'd0 - mx;
          out_oy_nxt    = 10'd0 - my;
          out_last_nxt  = 1'b1;
          pen_nxt       = '0;
          state_nxt     = StIdle;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_code_r <= 8'd32;
      last_code_r  <= 8'd127;
      gpr_r        <= 8'd16;
      cell_w_r     <= 8'd16;
      cell_h_r     <= 8'd16;
      u_step_r     <= 16'd4096;
      v_step_r     <= 16'd4096;
      align_r      <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        bfq_pkg::RegFirstCode:    first_code_r <= cfg_data[7:0];
        bfq_pkg::RegLastCode:     last_code_r  <= cfg_data[7:0];
        bfq_pkg::RegGlyphsPerRow: gpr_r        <= cfg_data[7:0];
        bfq_pkg::RegCellWidth:    cell_w_r     <= cfg_data[7:0];
        bfq_pkg::RegCellHeight:   cell_h_r     <= cfg_data[7:0];
        bfq_pkg::RegUStep:        u_step_r     <= cfg_data;
        bfq_pkg::RegVStep:        v_step_r     <= cfg_data;
        bfq_pkg::RegAlignment:    align_r      <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StIdle;
      vtx_r       <= '0;
      pen_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vtx_r       <= vtx_nxt;
      pen_r       <= pen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    tab_ok_r   <= tab_ok_nxt;
    w_r        <= w_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    u0_r       <= u0_nxt;
    u1_r       <= u1_nxt;
    v0_r       <= v0_nxt;
    v1_r       <= v1_nxt;
    x1_r       <= x1_nxt;
    out_kind_r <= out_kind_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_u_r    <= out_u_nxt;
    out_v_r    <= out_v_nxt;
    out_ox_r   <= out_ox_nxt;
    out_oy_r   <= out_oy_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_vertex_x      = out_x_r;
  assign out_vertex_y      = out_y_r;
  assign out_tex_u         = out_u_r;
  assign out_tex_v         = out_v_r;
  assign out_offset_x_half = out_ox_r;
  assign out_offset_y_half = out_oy_r;
  assign out_last          = out_last_r;

endmodule

// ----- design/bfq_checker.sv -----
// ----------------------------------------------------------------------------
// bfq_checker
// Port-level checks for the glyph quad generator, bound to the top level.
// ----------------------------------------------------------------------------
module bfq_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         cfg_we,
  input logic [bfq_pkg::CfgIdxW-1:0]  cfg_index,
  input logic [bfq_pkg::CfgDataW-1:0] cfg_data,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [1:0]                   in_action,
  input logic [7:0]                   in_code,
  input logic [7:0]                   in_width_value,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_kind,
  input logic [15:0]                  out_vertex_x,
  input logic [7:0]                   out_vertex_y,
  input logic [15:0]                  out_tex_u,
  input logic [15:0]                  out_tex_v,
  input logic signed [17:0]           out_offset_x_half,
  input logic signed [9:0]            out_offset_y_half,
  input logic                         out_last
);

  // an alignment result is always the only result of its transaction
  a_align_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == bfq_pkg::KindAlign) |-> out_last)
    else $error("alignment result without last");

  a_vertex_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == bfq_pkg::KindVertex)
      |-> (out_offset_x_half == 18'sd0) && (out_offset_y_half == 10'sd0))
    else $error("vertex result carries an offset");

  // the six vertices of a glyph leave back to back once the sink takes them
  a_quad_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("gap inside a glyph's vertex burst");

  // no new input while a glyph is still being emitted
  a_busy_during_quad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input ready in the middle of a glyph");

endmodule

bind bitmap_font_glyph_quad_generator_unit bfq_checker u_bfq_checker (.*);
